// File: hdl/theta_phase_stim_predictor_top_macros.svh
// Assertion macros for the theta-phase stimulation predictor checker.
// Needs a clock named clk and an active-low reset named arst_n in the using scope.
`ifndef THETA_PHASE_STIM_PREDICTOR_TOP_MACROS_SVH
`define THETA_PHASE_STIM_PREDICTOR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TPSP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TPSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/tpsp_pkg.sv
// Shared types, sizes and codes for the theta-phase stimulation predictor.
// Used by the stream interfaces, the sort unit, the predictor and the top level.
package tpsp_pkg;

	// Sizes
	localparam int Window   = 15;
	localparam int TimeBits = 32;
	localparam int SampleW  = 16;
	localparam int MidIdx   = (Window - 1) / 2;
	localparam int PtrW     = $clog2(Window);
	localparam int GapW     = TimeBits + 2;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;

	typedef logic signed [SampleW-1:0] sample_t;
	typedef logic signed [SampleW:0]   sdiff_t;
	typedef logic [TimeBits-1:0]       time_t;
	typedef logic signed [GapW-1:0]    gap_t;
	typedef logic [PtrW-1:0]           ptr_t;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_TARGET_MODE   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_AMP_THRESHOLD = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_STIM_DURATION = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_FULL_CYCLE    = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_QUARTER_CYCLE = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_STIM_DELAY    = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_MATCH_WINDOW  = 3'd6;

	typedef struct packed {
		logic        target_mode;
		logic [15:0] amplitude_threshold;
		logic [15:0] stim_duration;
		logic [15:0] full_cycle;
		logic [15:0] quarter_cycle;
		logic [15:0] stim_delay;
		logic [7:0]  match_window;
	} cfg_t;

	typedef enum logic [1:0] {
		SLOPE_ZERO = 2'b00,
		SLOPE_POS  = 2'b01,
		SLOPE_NEG  = 2'b11
	} slope_t;

	typedef enum logic [1:0] {
		SRT_IDLE,
		SRT_DEL,
		SRT_INS
	} srt_state_t;

	typedef enum logic [2:0] {
		PS_NONE,
		PS_REFR,
		PS_SEARCH,
		PS_EXTR,
		PS_PRED,
		PS_DIFF,
		PS_MATCH
	} pred_step_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SORT,
		ST_REFR,
		ST_SEARCH,
		ST_EXTR,
		ST_PRED,
		ST_DIFF,
		ST_MATCH,
		ST_DONE
	} seq_state_t;

	// Sort unit command and status
	typedef struct packed {
		logic    start;
		sample_t old_val;
		sample_t new_val;
	} srt_cmd_t;

	typedef struct packed {
		logic    done;
		sample_t median;
	} srt_stat_t;

	// Predictor command from the sequencer
	typedef struct packed {
		pred_step_t step;
		sample_t    sample;
		sample_t    median;
		slope_t     slope;
		slope_t     prev_slope;
		time_t      now;
	} pred_cmd_t;

endpackage

// File: hdl/tpsp_stream_if.sv
// Valid/ready stream interfaces for samples in and results out.
// Depends on tpsp_pkg for the payload types.
interface tpsp_sample_if;
	import tpsp_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface tpsp_result_if;
	import tpsp_pkg::*;

	logic    valid;
	logic    ready;
	logic    stimulate;
	sample_t median_level;

	modport source (output valid, output stimulate, output median_level, input ready);
	modport sink (input valid, input stimulate, input median_level, output ready);
endinterface

// File: hdl/tpsp_sorter.sv
// Sorted copy of the sample window, updated by removing the oldest sample and
// inserting the newest with one shared comparator. Depends on tpsp_pkg.
module tpsp_sorter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tpsp_pkg::srt_cmd_t   cmd,
	output tpsp_pkg::srt_stat_t  stat
);
	import tpsp_pkg::*;

	srt_state_t state_q, state_d;
	sample_t    sorted_q [Window];
	ptr_t       ptr_q;
	sample_t    del_key_q;
	sample_t    ins_key_q;
	logic       done_q;

	// Shared comparator on the entry under the scan pointer.
	sample_t cur;
	sample_t key;
	logic    hit_eq;
	logic    hit_gt;
	logic    at_last;
	logic    del_found;
	logic    ins_place;

	assign cur       = sorted_q[ptr_q];
	assign key       = (state_q == SRT_DEL) ? del_key_q : ins_key_q;
	assign hit_eq    = (cur == key);
	assign hit_gt    = (cur > key);
	assign at_last   = (ptr_q == PtrW'(Window - 1));
	assign del_found = hit_eq || at_last;
	assign ins_place = hit_gt || at_last;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			SRT_IDLE: begin
				if (cmd.start) state_d = SRT_DEL;
			end
			SRT_DEL: begin
				if (del_found) state_d = SRT_INS;
			end
			SRT_INS: begin
				if (ins_place) state_d = SRT_IDLE;
			end
			default: state_d = SRT_IDLE;
		endcase
	end

	// Status outputs.
	always_comb begin
		stat.done   = done_q;
		stat.median = sorted_q[MidIdx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SRT_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == SRT_INS) && ins_place;
		end
	end

	// Scan pointer and keys.
	always_ff @(posedge clk) begin
		if (state_q == SRT_IDLE && cmd.start) begin
			del_key_q <= cmd.old_val;
			ins_key_q <= cmd.new_val;
			ptr_q     <= '0;
		end else if (state_q == SRT_DEL) begin
			ptr_q <= del_found ? '0 : ptr_q + 1'b1;
		end else if (state_q == SRT_INS && !ins_place) begin
			ptr_q <= ptr_q + 1'b1;
		end
	end

	// Sorted array: close the gap on delete, open one on insert.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < Window; p++) sorted_q[p] <= '0;
		end else if (state_q == SRT_DEL && del_found) begin
			for (int p = 0; p < Window - 1; p++) begin
				if (PtrW'(p) >= ptr_q) sorted_q[p] <= sorted_q[p+1];
			end
		end else if (state_q == SRT_INS && ins_place) begin
			for (int p = 1; p < Window; p++) begin
				if (PtrW'(p) > ptr_q) sorted_q[p] <= sorted_q[p-1];
			end
			sorted_q[ptr_q] <= ins_key_q;
		end
	end

endmodule

// File: hdl/tpsp_predictor.sv
// Phase tracking, extremum qualification, stimulation prediction and match.
// Works one step per cycle as told by the sequencer. Depends on tpsp_pkg.
module tpsp_predictor (
	input  logic                clk,
	input  logic                arst_n,
	input  tpsp_pkg::cfg_t      cfg,
	input  tpsp_pkg::pred_cmd_t cmd,
	output logic                stim
);
	import tpsp_pkg::*;

	// Persistent tracking state.
	logic    searching_q;
	logic    refractory_q;
	time_t   search_start_q;
	time_t   last_stim_q;
	time_t   predicted_q;
	sample_t last_peak_q;
	sample_t last_trough_q;

	// Intermediate results between steps.
	time_t since_stim_q;
	time_t since_search_q;
	time_t now_less_delay_q;
	time_t dist_q;
	logic  gap_ok_q;
	logic  mag_ok_q;
	logic  qual_q;

	time_t  since_stim;
	time_t  since_search;
	gap_t   gap;
	logic   gap_ok;
	sdiff_t diff;
	logic [SampleW:0] mag;
	logic   mag_ok;
	logic   start_cond;
	logic   turn;
	time_t  pred;
	time_t  dist_abs;
	logic   match;

	// Elapsed times and the gap against the minimum cycle.
	assign since_stim   = cmd.now - last_stim_q;
	assign since_search = cmd.now - search_start_q;
	assign gap          = gap_t'(since_stim_q) - gap_t'(cfg.stim_delay);
	assign gap_ok       = (gap >= gap_t'(cfg.full_cycle));

	// Distance of the sample from the median.
	assign diff   = sdiff_t'(cmd.sample) - sdiff_t'(cmd.median);
	assign mag    = diff[SampleW] ? (SampleW+1)'(-diff) : (SampleW+1)'(diff);
	assign mag_ok = (mag >= (SampleW+1)'(cfg.amplitude_threshold));

	// Median crossing against the target phase.
	assign start_cond = cfg.target_mode
		? ((cmd.sample > cmd.median) && (cmd.slope == SLOPE_POS))
		: ((cmd.sample < cmd.median) && (cmd.slope == SLOPE_NEG));

	assign turn = (cmd.slope != cmd.prev_slope) && (cmd.slope != SLOPE_ZERO);

	assign pred     = now_less_delay_q + (since_search_q << 1);
	assign dist_abs = dist_q[TimeBits-1] ? -dist_q : dist_q;
	assign match    = (dist_abs <= time_t'(cfg.match_window));

	assign stim = refractory_q;

	always_ff @(posedge clk) begin
		case (cmd.step)
			PS_REFR: begin
				since_stim_q <= since_stim;
			end
			PS_SEARCH: begin
				gap_ok_q         <= gap_ok;
				mag_ok_q         <= mag_ok;
				now_less_delay_q <= cmd.now - time_t'(cfg.stim_delay);
			end
			PS_EXTR: begin
				since_search_q <= since_search;
				qual_q <= searching_q && turn && mag_ok_q && gap_ok_q &&
					(since_search >= time_t'(cfg.quarter_cycle));
			end
			PS_DIFF: begin
				dist_q <= predicted_q - cmd.now;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			searching_q    <= 1'b0;
			refractory_q   <= 1'b0;
			search_start_q <= '0;
			last_stim_q    <= '0;
			predicted_q    <= '0;
			last_peak_q    <= '0;
			last_trough_q  <= '0;
		end else begin
			case (cmd.step)
				// End of the refractory period.
				PS_REFR: begin
					if (refractory_q && since_stim > time_t'(cfg.stim_duration))
						refractory_q <= 1'b0;
				end
				// Start a search at a crossing against the target phase.
				PS_SEARCH: begin
					if (!searching_q && !refractory_q && start_cond) begin
						searching_q    <= 1'b1;
						search_start_q <= cmd.now;
					end
				end
				// Qualified extremum: track levels, predict on the tracked kind.
				PS_PRED: begin
					if (qual_q) begin
						if (cmd.slope == SLOPE_NEG) begin
							if (cfg.target_mode && cmd.sample > last_peak_q)
								predicted_q <= pred;
							last_peak_q <= cmd.sample;
						end else begin
							if (!cfg.target_mode && cmd.sample < last_trough_q)
								predicted_q <= pred;
							last_trough_q <= cmd.sample;
						end
					end
				end
				// Fire when the tick lies within the window of the prediction.
				PS_MATCH: begin
					if (!refractory_q && match) begin
						searching_q   <= 1'b0;
						refractory_q  <= 1'b1;
						last_stim_q   <= cmd.now;
						last_peak_q   <= cmd.median;
						last_trough_q <= cmd.median;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: hdl/theta_phase_stim_predictor_top.sv
// Theta-phase stimulation predictor. Takes one signed sample per transaction and
// returns one result per sample: the stimulate flag and the running median of the
// last 15 samples (0 and no stimulation while the first 15 samples fill the window).
// Samples are handled one at a time: ready is high only while the block is idle. Once the
// window is full, the spacing of consecutive samples is set by the two scans of one shared
// comparator through the sorted window (removing the oldest sample, then placing the
// newest) plus the load state, the sort hand-off, six predictor steps, the hand-off to the
// output register and the idle state. While the window fills, the predictor steps are
// skipped. A finished result waits in an output register, so the next sample is taken even
// while it is not yet read; only a result still unread when the next one is ready stalls.
// Depends on tpsp_pkg, the stream interfaces, tpsp_sorter and tpsp_predictor.
module theta_phase_stim_predictor_top (
	input  logic                            clk,
	input  logic                            arst_n,
	tpsp_sample_if.sink                     samples,
	tpsp_result_if.source                   results,
	input  logic                            cfg_we,
	input  logic [tpsp_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [tpsp_pkg::CfgDataW-1:0]   cfg_data
);
	import tpsp_pkg::*;

	cfg_t       cfg_q;
	seq_state_t state_q, state_d;

	// Window store and per-item registers.
	sample_t win_mem [Window];
	sample_t rd_q;
	ptr_t    wr_pos_q;
	logic    filled_q;
	logic    fill_only_q;
	sample_t sample_q;
	slope_t  slope_q;
	sample_t prev_sample_q;
	slope_t  prev_slope_q;
	time_t   tick_q;
	sample_t med_q;

	// Output register.
	logic    out_valid_q;
	logic    out_stim_q;
	sample_t out_med_q;

	logic       in_acc;
	logic       out_free;
	logic       in_ready;
	sdiff_t     step_diff;
	slope_t     slope_new;
	srt_cmd_t   srt_cmd;
	srt_stat_t  srt_stat;
	pred_cmd_t  pred_cmd;
	pred_step_t pred_step;
	logic       pred_stim;

	assign in_acc   = samples.valid && in_ready;
	assign out_free = !out_valid_q || results.ready;

	// Sign of the step from the previous sample.
	assign step_diff = sdiff_t'(samples.sample) - sdiff_t'(prev_sample_q);
	assign slope_new = (step_diff == '0) ? SLOPE_ZERO :
		(step_diff[SampleW] ? SLOPE_NEG : SLOPE_POS);

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_mode         <= 1'b0;
			cfg_q.amplitude_threshold <= 16'd0;
			cfg_q.stim_duration       <= 16'd100;
			cfg_q.full_cycle          <= 16'd125;
			cfg_q.quarter_cycle       <= 16'd31;
			cfg_q.stim_delay          <= 16'd0;
			cfg_q.match_window        <= 8'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET_MODE:   cfg_q.target_mode         <= cfg_data[0];
				REG_AMP_THRESHOLD: cfg_q.amplitude_threshold <= cfg_data[15:0];
				REG_STIM_DURATION: cfg_q.stim_duration       <= cfg_data[15:0];
				REG_FULL_CYCLE:    cfg_q.full_cycle          <= cfg_data[15:0];
				REG_QUARTER_CYCLE: cfg_q.quarter_cycle       <= cfg_data[15:0];
				REG_STIM_DELAY:    cfg_q.stim_delay          <= cfg_data[15:0];
				REG_MATCH_WINDOW:  cfg_q.match_window        <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (samples.valid) state_d = ST_LOAD;
			end
			ST_LOAD:   state_d = ST_SORT;
			ST_SORT: begin
				if (srt_stat.done) state_d = fill_only_q ? ST_DONE : ST_REFR;
			end
			ST_REFR:   state_d = ST_SEARCH;
			ST_SEARCH: state_d = ST_EXTR;
			ST_EXTR:   state_d = ST_PRED;
			ST_PRED:   state_d = ST_DIFF;
			ST_DIFF:   state_d = ST_MATCH;
			ST_MATCH:  state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		pred_step = PS_NONE;
		case (state_q)
			ST_REFR:   pred_step = PS_REFR;
			ST_SEARCH: pred_step = PS_SEARCH;
			ST_EXTR:   pred_step = PS_EXTR;
			ST_PRED:   pred_step = PS_PRED;
			ST_DIFF:   pred_step = PS_DIFF;
			ST_MATCH:  pred_step = PS_MATCH;
			default:   pred_step = PS_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// Window store: read the oldest entry and overwrite it in one access.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_q              <= win_mem[wr_pos_q];
			win_mem[wr_pos_q] <= samples.sample;
		end
	end

	// Per-item capture.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= samples.sample;
			slope_q  <= slope_new;
		end
		if (state_q == ST_SORT && srt_stat.done)
			med_q <= fill_only_q ? '0 : srt_stat.median;
	end

	// Write position, fill tracking and history.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pos_q      <= '0;
			filled_q      <= 1'b0;
			fill_only_q   <= 1'b1;
			prev_sample_q <= '0;
			prev_slope_q  <= SLOPE_ZERO;
			tick_q        <= '0;
		end else begin
			if (in_acc) begin
				fill_only_q <= !filled_q;
				if (wr_pos_q == PtrW'(Window - 1)) begin
					wr_pos_q <= '0;
					filled_q <= 1'b1;
				end else begin
					wr_pos_q <= wr_pos_q + 1'b1;
				end
			end
			if (state_q == ST_DONE && out_free) begin
				prev_sample_q <= sample_q;
				prev_slope_q  <= slope_q;
				tick_q        <= tick_q + 1'b1;
			end
		end
	end

	// Sort unit command: before the window is full the replaced entry is zero.
	always_comb begin
		srt_cmd.start   = (state_q == ST_LOAD);
		srt_cmd.old_val = fill_only_q ? '0 : rd_q;
		srt_cmd.new_val = sample_q;
	end

	tpsp_sorter u_sorter (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (srt_cmd),
		.stat   (srt_stat)
	);

	always_comb begin
		pred_cmd.step       = pred_step;
		pred_cmd.sample     = sample_q;
		pred_cmd.median     = med_q;
		pred_cmd.slope      = slope_q;
		pred_cmd.prev_slope = prev_slope_q;
		pred_cmd.now        = tick_q;
	end

	tpsp_predictor u_predictor (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cmd    (pred_cmd),
		.stim   (pred_stim)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_stim_q <= fill_only_q ? 1'b0 : pred_stim;
			out_med_q  <= med_q;
		end
	end

	assign samples.ready        = in_ready;
	assign results.valid        = out_valid_q;
	assign results.stimulate    = out_stim_q;
	assign results.median_level = out_med_q;

endmodule

// File: hdl/tpsp_checker.sv
// Port-level checks for the theta-phase stimulation predictor, bound to its top.
// Depends on the assertion macro header.
`include "theta_phase_stim_predictor_top_macros.svh"

module tpsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_stim,
	input logic [15:0] out_median
);

	// One sample at a time: ready drops right after a transaction.
	`TPSP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready stayed high after an input transaction")

	// A result never appears in the cycle right after a sample is taken.
	`TPSP_ASSERT_SAME(a_no_instant_result, $rose(out_valid), !$past(in_valid && in_ready), "result appeared one cycle after its sample")

	// A stalled result holds its value.
	`TPSP_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(out_stim) && $stable(out_median), "stalled result changed")

endmodule

bind theta_phase_stim_predictor_top tpsp_checker u_tpsp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (samples.valid),
	.in_ready   (samples.ready),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.out_stim   (results.stimulate),
	.out_median (results.median_level)
);

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for theta_phase_stim_predictor_top: directed table, then shaped waves.
// Depends on tpsp_pkg, the stream interfaces in tpsp_stream_if.sv and the top-level RTL.
module tb;
	import tpsp_pkg::*;

	localparam int HalfPeriod   = 5;
	localparam int SettleCycles = 64;
	localparam int QuietLimit   = 2000;
	localparam int PhaseItems   = 185;
	localparam int PhaseCount   = 8;
	localparam int DirCount     = 25;
	localparam int MaxShown     = 30;
	// Index past the last register; the block must ignore writes to it.
	localparam logic [CfgIdxW-1:0] REG_SPARE = 3'd7;

	typedef struct packed {
		logic    stimulate;
		sample_t median_level;
	} stim_out_t;

	typedef struct packed {
		sample_t   s;
		logic      typed;
		stim_out_t want;
	} dir_row_t;

	typedef enum int {TRACE_WAVE, TRACE_FLAT, TRACE_NOISE} trace_kind_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	tpsp_sample_if sample_ch();
	tpsp_result_if result_ch();

	theta_phase_stim_predictor_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(sample_ch),
		.results(result_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #HalfPeriod clk = ~clk;

	// Shadow state of the phase tracker.
	cfg_t    cfg_now;
	sample_t win_vals [Window];
	int      win_next;
	bit      win_full;
	time_t   tick;
	sample_t prev_s;
	int      prev_slope;
	bit      hunting;
	bit      holding;
	time_t   hunt_start;
	time_t   stim_tick;
	time_t   aim_tick;
	sample_t peak_lvl;
	sample_t trough_lvl;

	stim_out_t stim_median_due[$];
	stim_out_t owed_now;
	int mismatches;
	int results_seen;
	int quiet_cycles;
	int idle_pct;

	// Trace generator state.
	trace_kind_t seg_kind;
	int seg_left;
	int wave_period;
	int wave_amp;
	int wave_off;
	int wave_noise;
	int wave_pos;
	sample_t flat_val;

	// Directed rows: window fill with field extremes, then zero slope, crossings and extrema.
	// Columns: sample, expectation typed in, stimulate, median.
	dir_row_t directed_rows [DirCount] = '{
		{16'sh7FFF, 1'b1, 1'b0, 16'sh0000},
		{16'sh8000, 1'b1, 1'b0, 16'sh0000},
		{16'sh0000, 1'b1, 1'b0, 16'sh0000},
		{-16'sd1,   1'b1, 1'b0, 16'sh0000},
		{16'sd1,    1'b1, 1'b0, 16'sh0000},
		{16'sh7FFF, 1'b1, 1'b0, 16'sh0000},
		{16'sh8000, 1'b1, 1'b0, 16'sh0000},
		{16'sd100,  1'b1, 1'b0, 16'sh0000},
		{-16'sd100, 1'b1, 1'b0, 16'sh0000},
		{16'sd5,    1'b1, 1'b0, 16'sh0000},
		{16'sd5,    1'b1, 1'b0, 16'sh0000},
		{16'sd5,    1'b1, 1'b0, 16'sh0000},
		{-16'sd7,   1'b1, 1'b0, 16'sh0000},
		{16'sd200,  1'b1, 1'b0, 16'sh0000},
		{-16'sd300, 1'b1, 1'b0, 16'sh0000},
		{16'sh8000, 1'b0, 1'b0, 16'sh0000},
		{16'sh7FFF, 1'b0, 1'b0, 16'sh0000},
		{16'sh7FFF, 1'b0, 1'b0, 16'sh0000},
		{16'sd0,    1'b0, 1'b0, 16'sh0000},
		{-16'sd20000, 1'b0, 1'b0, 16'sh0000},
		{-16'sd30000, 1'b0, 1'b0, 16'sh0000},
		{-16'sd10000, 1'b0, 1'b0, 16'sh0000},
		{16'sd10000,  1'b0, 1'b0, 16'sh0000},
		{16'sd20000,  1'b0, 1'b0, 16'sh0000},
		{16'sd15000,  1'b0, 1'b0, 16'sh0000}
	};

	// Return the tracker to its power-up state, registers included.
	function automatic void clear_tracker();
		cfg_now.target_mode = 1'b0;
		cfg_now.amplitude_threshold = 16'd0;
		cfg_now.stim_duration = 16'd100;
		cfg_now.full_cycle = 16'd125;
		cfg_now.quarter_cycle = 16'd31;
		cfg_now.stim_delay = 16'd0;
		cfg_now.match_window = 8'd2;
		for (int i = 0; i < Window; i++)
			win_vals[i] = '0;
		win_next = 0;
		win_full = 1'b0;
		tick = '0;
		prev_s = '0;
		prev_slope = 0;
		hunting = 1'b0;
		holding = 1'b0;
		hunt_start = '0;
		stim_tick = '0;
		aim_tick = '0;
		peak_lvl = '0;
		trough_lvl = '0;
	endfunction

	// Advance the tracker by one sample and produce the stimulate flag and median.
	function automatic void track_theta_phase(input sample_t s, output stim_out_t r);
		sample_t ordered [Window];
		sample_t v;
		sample_t med;
		int      slope;
		int      j;
		int      mag;
		time_t   since_stim;
		time_t   since_hunt;
		time_t   aim;
		time_t   d;
		longint  gap;
		longint  spread;
		med = '0;
		if (s > prev_s)
			slope = 1;
		else if (s < prev_s)
			slope = -1;
		else
			slope = 0;

		win_vals[win_next] = s;
		win_next = (win_next + 1 >= Window) ? 0 : win_next + 1;

		if (!win_full) begin
			// Filling ticks only load the window.
			if (win_next == 0)
				win_full = 1'b1;
		end else begin
			since_stim = tick - stim_tick;

			// Insertion sort of the window; the median is the middle rank.
			for (int i = 0; i < Window; i++) begin
				v = win_vals[i];
				j = i;
				while (j > 0 && ordered[j-1] > v) begin
					ordered[j] = ordered[j-1];
					j--;
				end
				ordered[j] = v;
			end
			med = ordered[MidIdx];

			if (holding && since_stim > time_t'(cfg_now.stim_duration))
				holding = 1'b0;

			// A median crossing against the target phase opens a search.
			if (!hunting && !holding) begin
				if ((cfg_now.target_mode == 1'b0 && s < med && slope == -1) ||
				    (cfg_now.target_mode == 1'b1 && s > med && slope == 1)) begin
					hunting = 1'b1;
					hunt_start = tick;
				end
			end

			// Slope-sign change: a qualified extremum may set a new prediction.
			if (hunting && slope != prev_slope && slope != 0) begin
				mag = int'(s) - int'(med);
				if (mag < 0)
					mag = -mag;
				since_hunt = tick - hunt_start;
				gap = longint'({32'd0, since_stim}) - longint'({48'd0, cfg_now.stim_delay});
				if (mag >= int'(cfg_now.amplitude_threshold) &&
				    gap >= longint'({48'd0, cfg_now.full_cycle}) &&
				    since_hunt >= time_t'(cfg_now.quarter_cycle)) begin
					aim = tick + (since_hunt << 1) - time_t'(cfg_now.stim_delay);
					if (slope == -1) begin
						if (cfg_now.target_mode == 1'b1 && s > peak_lvl)
							aim_tick = aim;
						peak_lvl = s;
					end else begin
						if (cfg_now.target_mode == 1'b0 && s < trough_lvl)
							aim_tick = aim;
						trough_lvl = s;
					end
				end
			end

			// Fire when the current tick lies close enough to the prediction.
			if (!holding) begin
				d = aim_tick - tick;
				spread = longint'($signed(d));
				if (spread < 0)
					spread = -spread;
				if (spread <= longint'({56'd0, cfg_now.match_window})) begin
					hunting = 1'b0;
					holding = 1'b1;
					stim_tick = tick;
					trough_lvl = med;
					peak_lvl = med;
				end
			end
		end

		prev_s = s;
		prev_slope = slope;
		tick = tick + 1'b1;
		r.stimulate = win_full ? holding : 1'b0;
		r.median_level = med;
	endfunction

	// Next sample of a synthetic field potential: mostly noisy triangle waves, with flat
	// stretches, broadband noise and single glitches to break the rhythm.
	function automatic sample_t next_trace_sample();
		int v;
		int p;
		int half;
		if (seg_left == 0) begin
			seg_left = $urandom_range(20, 200);
			if ($urandom_range(0, 9) < 7)
				seg_kind = TRACE_WAVE;
			else
				seg_kind = $urandom_range(0, 1) ? TRACE_FLAT : TRACE_NOISE;
			wave_period = $urandom_range(8, 80);
			wave_amp = $urandom_range(20, 20000);
			wave_off = int'($urandom_range(0, 10000)) - 5000;
			wave_noise = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, wave_amp / 8);
			wave_pos = $urandom_range(0, wave_period - 1);
			flat_val = sample_t'($urandom);
		end
		seg_left--;
		case (seg_kind)
			TRACE_WAVE: begin
				if ($urandom_range(0, 99) < 3)
					return sample_t'($urandom);
				p = wave_pos;
				half = wave_period / 2;
				wave_pos = (wave_pos + 1) % wave_period;
				if (p < half)
					v = -wave_amp + 2 * wave_amp * p / half;
				else
					v = wave_amp - 2 * wave_amp * (p - half) / (wave_period - half);
				v += wave_off;
				if (wave_noise != 0)
					v += int'($urandom_range(0, 2 * wave_noise)) - wave_noise;
				if (v > 32767)
					v = 32767;
				if (v < -32768)
					v = -32768;
				return sample_t'(v);
			end
			TRACE_FLAT: begin
				if ($urandom_range(0, 7) == 0)
					flat_val = sample_t'($urandom);
				return flat_val;
			end
			default: begin
				return sample_t'($urandom);
			end
		endcase
	endfunction

	function automatic cfg_t make_cfg(input logic mode, input int thr, input int dur,
			input int full, input int quarter, input int delay, input int mw);
		cfg_t c;
		c.target_mode = mode;
		c.amplitude_threshold = 16'(thr);
		c.stim_duration = 16'(dur);
		c.full_cycle = 16'(full);
		c.quarter_cycle = 16'(quarter);
		c.stim_delay = 16'(delay);
		c.match_window = 8'(mw);
		return c;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		if (mismatches <= MaxShown)
			$display("MISMATCH %s on result %0d: got %0d, expected %0d",
				what, results_seen, got, want);
	endtask

	task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// Write every register; spare upper bits carry junk that the block must drop.
	task automatic load_config(input cfg_t c);
		put_reg(REG_TARGET_MODE, {15'($urandom), c.target_mode});
		put_reg(REG_AMP_THRESHOLD, c.amplitude_threshold);
		put_reg(REG_STIM_DURATION, c.stim_duration);
		put_reg(REG_FULL_CYCLE, c.full_cycle);
		put_reg(REG_QUARTER_CYCLE, c.quarter_cycle);
		put_reg(REG_STIM_DELAY, c.stim_delay);
		put_reg(REG_MATCH_WINDOW, {8'($urandom), c.match_window});
		put_reg(REG_SPARE, 16'($urandom));
		cfg_we <= 1'b0;
		cfg_now = c;
	endtask

	// One sample transaction; the tracker runs when the block takes it.
	task automatic send_sample(input sample_t s, input bit typed, input stim_out_t want);
		stim_out_t predicted;
		stim_out_t owed;
		sample_ch.valid <= 1'b1;
		sample_ch.sample <= s;
		do begin
			@(posedge clk);
		end while (!sample_ch.ready);
		track_theta_phase(s, predicted);
		owed = typed ? want : predicted;
		stim_median_due = {stim_median_due, owed};
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Hold off new samples until every pending result is out and the block is quiet.
	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		while (stim_median_due.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Result side: ready with random stall bursts.
	initial begin
		int stall_left;
		stall_left = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				result_ch.ready <= 1'b0;
				stall_left = $urandom_range(0, 4);
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each result transaction with the oldest pending expectation.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (stim_median_due.size() == 0) begin
				report_mismatch("result with nothing pending", result_ch.median_level, 0);
			end else begin
				owed_now = stim_median_due.pop_front();
				if (result_ch.stimulate !== owed_now.stimulate)
					report_mismatch("stimulate", result_ch.stimulate, owed_now.stimulate);
				if (result_ch.median_level !== owed_now.median_level)
					report_mismatch("median_level", result_ch.median_level,
						owed_now.median_level);
			end
		end
	end

	// Watchdog on cycles with no transaction on either channel.
	always @(posedge clk) begin
		if (!arst_n || (sample_ch.valid && sample_ch.ready) ||
		    (result_ch.valid && result_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QuietLimit) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Main sequence: reset, directed table, then shaped random phases.
	initial begin
		cfg_t phase_cfg;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_TARGET_MODE;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.sample = '0;
		idle_pct = 0;
		mismatches = 0;
		results_seen = 0;
		quiet_cycles = 0;
		seg_left = 0;
		clear_tracker();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A wide match window lets the reset prediction fire on the first filled tick.
		load_config(make_cfg(1'b0, 0, 4, 0, 0, 0, 255));
		idle_pct = 15;
		for (int i = 0; i < DirCount; i++)
			send_sample(directed_rows[i].s, directed_rows[i].typed, directed_rows[i].want);

		for (int ph = 1; ph <= PhaseCount; ph++) begin
			drain_results();
			case (ph)
				1: phase_cfg = make_cfg(1'b0, 0, 20, 10, 3, 0, 2);
				2: phase_cfg = make_cfg(1'b1, 100, 50, 40, 5, 4, 3);
				3: phase_cfg = make_cfg(1'b0, 65535, 0, 0, 0, 0, 0);
				4: phase_cfg = make_cfg(1'b1, 0, 65535, 65535, 65535, 65535, 255);
				5: phase_cfg = make_cfg(1'b0, 0, 0, 0, 0, 0, 255);
				PhaseCount: phase_cfg = make_cfg(1'b1, 10, 15, 20, 4, 2, 2);
				default: phase_cfg = make_cfg($urandom_range(0, 1), $urandom_range(0, 3000),
					$urandom_range(5, 80), $urandom_range(0, 100), $urandom_range(0, 20),
					$urandom_range(0, 10), $urandom_range(0, 6));
			endcase
			load_config(phase_cfg);
			// Idle odds vary per phase; the closing phase runs without idling.
			if (ph == PhaseCount || ph % 3 == 0)
				idle_pct = 0;
			else if (ph % 3 == 1)
				idle_pct = 15;
			else
				idle_pct = 40;
			for (int n = 0; n < PhaseItems; n++)
				send_sample(next_trace_sample(), 1'b0, '0);
		end

		drain_results();
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
